// File: hw/rtl/ugtc_pkg.sv
// Shared types and constants for the graph tree check block.
package ugtc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int VW           = 8;    // vertex index width
    localparam int NVW          = 9;    // vertex count width
    localparam int EAW          = 10;   // edge store address width
    localparam int ECW          = 11;   // edge count width
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BADVERT  = 2'd2;

    typedef struct packed {
        logic [1:0]    func;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_item;

endpackage

// File: hw/rtl/ugtc_front.sv
// Input side: takes stream transactions, drops unused codes, queues work items.
module ugtc_front
    import ugtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        i_pop,
    output logic        o_valid,
    output t_item       o_item
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    t_item            w_in;
    logic             w_push, w_pop;

    assign w_in.func     = s_axis_tdata[1:0];
    assign w_in.vertex_a = s_axis_tdata[9:2];
    assign w_in.vertex_b = s_axis_tdata[17:10];

    assign s_axis_tready = (r_cnt != QDEPTH[QAW:0]);
    assign w_push = s_axis_tvalid && s_axis_tready && (w_in.func != FUNC_NONE);
    assign w_pop  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hw/rtl/ugtc_back.sv
// Execution side: edge store, reachability sweep and result register.
module ugtc_back
    import ugtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_EREAD = 3'd2;
    localparam logic [2:0] S_VREAD = 3'd3;
    localparam logic [2:0] S_VUPD  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [15:0]    edge_mem [MAX_EDGES];
    logic           vis_mem  [MAX_VERTICES];

    logic [2:0]     r_state, n_state;
    logic [NVW-1:0] r_nv;
    logic [ECW-1:0] r_ecount, n_ecount;
    logic           r_ovf, n_ovf, r_bad, n_bad;
    logic           r_qbad, n_qbad, r_chg, n_chg;
    logic [EAW-1:0] r_idx, n_idx;
    logic [VW-1:0]  r_ccnt, n_ccnt;
    logic [NVW-1:0] r_vcnt, n_vcnt;
    logic [VW-1:0]  r_ea, r_eb;
    logic [15:0]    r_eq;
    logic           r_va, r_vb;
    logic           r_oval, n_oval;
    logic [2:0]     r_odata, n_odata;

    logic           w_ewe;
    logic [15:0]    w_ewd;
    logic           w_vwe, w_vwd;
    logic [VW-1:0]  w_vwa;
    logic [NVW-1:0] w_cfg_eff;
    logic           w_a_bad, w_b_bad, w_last, w_chg_now, w_badall, w_tree;

    // clamp the vertex count into 1..MAX_VERTICES
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_eff = NVW'(1);
        end else if (i_cfg_wdata > NVW'(MAX_VERTICES)) begin
            w_cfg_eff = NVW'(MAX_VERTICES);
        end else begin
            w_cfg_eff = i_cfg_wdata;
        end
    end

    assign w_a_bad   = ({1'b0, r_eq[7:0]}  >= r_nv);
    assign w_b_bad   = ({1'b0, r_eq[15:8]} >= r_nv);
    assign w_last    = ({1'b0, r_idx} == (r_ecount - 1'b1));
    assign w_chg_now = r_va ^ r_vb;
    assign w_badall  = r_bad || r_qbad;
    assign w_tree    = (r_vcnt == r_nv) && (r_ecount == ECW'(r_nv - 1'b1));

    always_comb begin
        n_state  = r_state;
        n_ecount = r_ecount;
        n_ovf    = r_ovf;
        n_bad    = r_bad;
        n_qbad   = r_qbad;
        n_chg    = r_chg;
        n_idx    = r_idx;
        n_ccnt   = r_ccnt;
        n_vcnt   = r_vcnt;
        n_oval   = r_oval;
        n_odata  = r_odata;
        o_q_pop  = 1'b0;
        w_ewe    = 1'b0;
        w_ewd    = {i_q_item.vertex_b, i_q_item.vertex_a};
        w_vwe    = 1'b0;
        w_vwa    = r_ccnt;
        w_vwd    = 1'b0;

        if (r_oval && m_axis_tready) n_oval = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.func)
                        FUNC_CLEAR: begin
                            n_ecount = '0;
                            n_ovf    = 1'b0;
                            n_bad    = 1'b0;
                        end
                        FUNC_ADD: begin
                            if (({1'b0, i_q_item.vertex_a} >= r_nv) ||
                                ({1'b0, i_q_item.vertex_b} >= r_nv)) begin
                                n_bad = 1'b1;
                            end else if (r_ecount == ECW'(MAX_EDGES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_ewe    = 1'b1;
                                n_ecount = r_ecount + 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            n_state = S_CLR;
                            n_ccnt  = '0;
                            n_qbad  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                // vertex 0 is marked as the walk's start
                w_vwe  = 1'b1;
                w_vwa  = r_ccnt;
                w_vwd  = (r_ccnt == '0);
                n_ccnt = r_ccnt + 1'b1;
                if (r_ccnt == VW'(MAX_VERTICES - 1)) begin
                    n_vcnt = NVW'(1);
                    n_idx  = '0;
                    n_chg  = 1'b0;
                    n_state = (r_ecount == '0) ? S_DONE : S_EREAD;
                end
            end
            S_EREAD: begin
                n_state = S_VREAD;
            end
            S_VREAD: begin
                if (w_a_bad || w_b_bad) n_qbad = 1'b1;
                n_state = S_VUPD;
            end
            S_VUPD: begin
                if (w_chg_now) begin
                    w_vwe  = 1'b1;
                    w_vwa  = r_va ? r_eb : r_ea;
                    w_vwd  = 1'b1;
                    n_vcnt = r_vcnt + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (w_last) begin
                    n_idx = '0;
                    n_chg = 1'b0;
                    if ((r_chg || w_chg_now) && !r_ovf && !w_badall) begin
                        n_state = S_EREAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_chg   = r_chg || w_chg_now;
                    n_state = S_EREAD;
                end
            end
            S_DONE: begin
                if (!r_oval || m_axis_tready) begin
                    n_oval = 1'b1;
                    if (w_badall) begin
                        n_odata = {ST_BADVERT, 1'b0};
                    end else if (r_ovf) begin
                        n_odata = {ST_OVERFLOW, 1'b0};
                    end else begin
                        n_odata = {ST_OK, w_tree};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ewe) edge_mem[r_ecount[EAW-1:0]] <= w_ewd;
        r_eq <= edge_mem[r_idx];
        if (w_vwe) vis_mem[w_vwa] <= w_vwd;
        r_va <= vis_mem[r_eq[7:0]];
        r_vb <= vis_mem[r_eq[15:8]];
        if (r_state == S_VREAD) begin
            r_ea <= r_eq[7:0];
            r_eb <= r_eq[15:8];
        end
        r_odata <= n_odata;
        r_idx   <= n_idx;
        r_ccnt  <= n_ccnt;
        r_vcnt  <= n_vcnt;
        r_chg   <= n_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nv     <= NVW'(1);
            r_ecount <= '0;
            r_ovf    <= 1'b0;
            r_bad    <= 1'b0;
            r_qbad   <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ecount <= n_ecount;
            r_ovf    <= n_ovf;
            r_bad    <= n_bad;
            r_qbad   <= n_qbad;
            r_oval   <= n_oval;
            if (i_cfg_we) r_nv <= w_cfg_eff;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {5'd0, r_odata};

endmodule

// File: hw/rtl/undirected_graph_tree_check_top.sv
// Top level of the undirected graph tree check block.
//
// Input stream s_axis_*: one transaction per command (clear, add edge,
// query). Unused command code 3 is accepted and dropped. A four-entry
// queue sits between the front and the execution side.
// Output stream m_axis_*: one transaction per query with is_tree and status.
// i_cfg_we / i_cfg_wdata write the vertex count (0 acts as 1, larger than
// 256 acts as 256); write it only while the block is idle.
// Clear and add are carried out directly in the idle state of the execution side.
// A query first clears the visited map, then sweeps the edge list, taking
// each edge through the edge read, vertex read and vertex update states,
// and repeats the sweep until no new vertex is marked, a bad vertex has
// been seen or the edge list has overflowed.
// While a query runs the queue fills and s_axis_tready drops.
// The result register holds while m_axis_tready is low; the next query's
// result waits for it to drain. Reset empties the queue, the edge list and flags,
// and sets the vertex count to 1.
module undirected_graph_tree_check_top
    import ugtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // func[1:0], vertex_a[9:2], vertex_b[17:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // is_tree[0], status[2:1]
);

    logic  w_pop, w_qvalid;
    t_item w_item;

    ugtc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_pop         (w_pop),
        .o_valid       (w_qvalid),
        .o_item        (w_item)
    );

    ugtc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (w_qvalid),
        .i_q_item      (w_item),
        .o_q_pop       (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: hw/rtl/ugtc_checker.sv
// Port-level checks for the graph tree check block, bound to the top level.
module ugtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3) && (m_axis_tdata[7:3] == 5'd0))
        else $error("bad result encoding");

    a_tree_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'd0)
        else $error("tree reported with error status");

endmodule

bind undirected_graph_tree_check_top ugtc_checker u_ugtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
